### rtl/core/sitrd_pkg.sv
// Package for the signed integer to radix text block.
// Holds the shared constants, reset values and the divider status type.
// Depends on nothing.
`timescale 1ns / 1ps

package sitrd_pkg;

   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int MAX_RADIX          = 16;

   localparam int RADIX_W     = 5;
   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 8;
   localparam int ALPHA_CHARS = 16;
   localparam int ALPHA_W     = 64;
   localparam int CSR_INDEX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_HIGH = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
   localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h6665_6463_6261_3938;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd33;
   localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;

   typedef struct packed {
      logic               done;
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

endpackage

### rtl/core/sitrd_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Divides an unsigned VALUE_BITS-bit word by the radix.
// Depends on sitrd_pkg.
`timescale 1ns / 1ps

module sitrd_divider #(
   parameter int VALUE_BITS = sitrd_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [VALUE_BITS-1:0]           dividend,
   input  logic [sitrd_pkg::RADIX_W-1:0]   divisor,
   output logic [VALUE_BITS-1:0]           quotient,
   output sitrd_pkg::div_status_type       status
);
   import sitrd_pkg::*;

   localparam int CNT_W = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RADIX_W-1:0]    partial;
   logic [RADIX_W-1:0]    diff;
   logic                  fits;

   // The remainder stays below the divisor, so it fits in one digit.
   assign partial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign fits    = (partial >= divisor);
   assign diff    = partial - divisor;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? diff[DIGIT_W-1:0] : partial[DIGIT_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient         = quo_ff;
   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

### rtl/core/signed_integer_to_radix_digits_top.sv
// Top level of the signed integer to radix text block.
// Checks the alphabet, converts the value digit by digit and streams the characters.
// Depends on sitrd_pkg and sitrd_divider.
`timescale 1ns / 1ps

//  Channel   Ports                                 Direction  Word
//  --------  ------------------------------------  ---------  ---------------------------
//  req       req_valid/req_ready, req_value        in         one signed value
//  rsp       rsp_valid/rsp_ready, rsp_char_code,   out        one character of the text
//            rsp_empty_res, rsp_last
//  csr       csr_valid/csr_ready, csr_index,       in         one register write
//            csr_data
//
// One value is converted at a time. The alphabet check steps through the characters in
// use one by one; a radix out of range is caught as the value is accepted, and the
// empty state then offers the empty word. Every digit is worked out in the bit-serial
// divider, and the characters then leave one by one as the output side takes them.
// Reset is synchronous and restores the radix and alphabet to decimal digits.
// A stalled output only holds the character stream; the next value is accepted as
// soon as the last character sits in the output register.

module signed_integer_to_radix_digits_top #(
   parameter int VALUE_BITS = sitrd_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [VALUE_BITS-1:0]       req_value,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sitrd_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                               rsp_empty_res,
   output logic                               rsp_last,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sitrd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sitrd_pkg::ALPHA_W-1:0]      csr_data
);
   import sitrd_pkg::*;

   localparam int IDX_W = $clog2(VALUE_BITS);
   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int AIDX_W = $clog2(ALPHA_CHARS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_SIGN,
      S_EMIT,
      S_EMPTY
   } state_type;

   // Control state.
   state_type             state_ff, state_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [ALPHA_W-1:0]    alpha_low_ff, alpha_low_in;
   logic [ALPHA_W-1:0]    alpha_high_ff, alpha_high_in;
   logic                  neg_ff, neg_in;
   logic [AIDX_W-1:0]     check_idx_ff, check_idx_in;
   logic [CNT_W-1:0]      digit_count_ff, digit_count_in;
   logic [IDX_W-1:0]      emit_idx_ff, emit_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload.
   logic [VALUE_BITS-1:0] quotient_work_ff, quotient_work_in;
   logic [DIGIT_W-1:0]    digit_store_ff [VALUE_BITS];
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [CHAR_W-1:0]     alpha_chars [ALPHA_CHARS];
   logic [CHAR_W-1:0]     check_char;
   logic                  check_dup;
   logic                  check_bad;
   logic                  check_final;
   logic                  out_free;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [VALUE_BITS-1:0] div_quotient;
   div_status_type        div_status;
   logic                  digit_we;

   // Alphabet characters, digit value 0 in the lowest byte of the low register.
   always_comb begin
      for (int i = 0; i < ALPHA_CHARS / 2; i++) begin
         alpha_chars[i]                   = alpha_low_ff[i*CHAR_W +: CHAR_W];
         alpha_chars[i + ALPHA_CHARS / 2] = alpha_high_ff[i*CHAR_W +: CHAR_W];
      end
   end

   // One character is checked per cycle against the characters before it.
   assign check_char = alpha_chars[check_idx_ff];

   always_comb begin
      check_dup = 1'b0;
      for (int j = 0; j < ALPHA_CHARS; j++) begin
         if ((AIDX_W'(j) < check_idx_ff) && (alpha_chars[j] == check_char)) begin
            check_dup = 1'b1;
         end
      end
   end

   assign check_bad = check_dup || (check_char == CHAR_PLUS) || (check_char == CHAR_MINUS)
                      || (check_char < CHAR_LOW) || (check_char > CHAR_HIGH);
   assign check_final = ({1'b0, check_idx_ff} + 1'b1) == radix_ff;

   // The output register can take a new word when empty or being emptied.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // The divider restarts on its own quotient until that quotient reaches zero.
   assign div_dividend = (state_ff == S_CHECK) ? quotient_work_ff : div_quotient;
   assign digit_we     = (state_ff == S_DIV) && div_status.done;
   assign div_start    = ((state_ff == S_CHECK) && !check_bad && check_final)
                         || (digit_we && (div_quotient != '0));

   sitrd_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (radix_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in         = state_ff;
      radix_in         = radix_ff;
      alpha_low_in     = alpha_low_ff;
      alpha_high_in    = alpha_high_ff;
      neg_in           = neg_ff;
      check_idx_in     = check_idx_ff;
      digit_count_in   = digit_count_ff;
      emit_idx_in      = emit_idx_ff;
      quotient_work_in = quotient_work_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_char_in      = rsp_char_ff;
      rsp_empty_in     = rsp_empty_ff;
      rsp_last_in      = rsp_last_ff;

      // Configuration must be written only while the block is idle; the block itself does not enforce this.
      if (csr_valid) begin
         case (csr_index)
            CSR_RADIX:      radix_in      = csr_data[RADIX_W-1:0];
            CSR_ALPHA_LOW:  alpha_low_in  = csr_data;
            CSR_ALPHA_HIGH: alpha_high_in = csr_data;
            default:        ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               neg_in         = req_value[VALUE_BITS-1];
               // Two's complement negation; the most negative value maps to 2^(N-1).
               quotient_work_in = req_value[VALUE_BITS-1] ? (~req_value + 1'b1)
                                                           : req_value;
               check_idx_in   = '0;
               digit_count_in = '0;
               if ((radix_ff < RADIX_W'(2)) || (radix_ff > RADIX_W'(MAX_RADIX))) begin
                  state_in = S_EMPTY;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (check_bad) begin
               state_in = S_EMPTY;
            end else if (check_final) begin
               state_in = S_DIV;
            end else begin
               check_idx_in = check_idx_ff + 1'b1;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               digit_count_in = digit_count_ff + 1'b1;
               if (div_quotient == '0) begin
                  emit_idx_in = digit_count_ff[IDX_W-1:0];
                  state_in    = neg_ff ? S_SIGN : S_EMIT;
               end
            end
         end
         S_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_empty_in = 1'b0;
               rsp_last_in  = 1'b0;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = alpha_chars[digit_store_ff[emit_idx_ff]];
               rsp_empty_in = 1'b0;
               rsp_last_in  = (emit_idx_ff == '0);
               if (emit_idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff - 1'b1;
               end
            end
         end
         S_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_NONE;
               rsp_empty_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         radix_ff       <= RADIX_RESET;
         alpha_low_ff   <= ALPHA_LOW_RESET;
         alpha_high_ff  <= ALPHA_HIGH_RESET;
         neg_ff         <= 1'b0;
         check_idx_ff   <= '0;
         digit_count_ff <= '0;
         emit_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         radix_ff       <= radix_in;
         alpha_low_ff   <= alpha_low_in;
         alpha_high_ff  <= alpha_high_in;
         neg_ff         <= neg_in;
         check_idx_ff   <= check_idx_in;
         digit_count_ff <= digit_count_in;
         emit_idx_ff    <= emit_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Digits land least significant first and are read back in reverse.
   always_ff @(posedge clock) begin
      quotient_work_ff <= quotient_work_in;
      rsp_char_ff      <= rsp_char_in;
      rsp_empty_ff     <= rsp_empty_in;
      rsp_last_ff      <= rsp_last_in;
      if (digit_we) begin
         digit_store_ff[digit_count_ff[IDX_W-1:0]] <= div_status.remainder;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### verif/signed_integer_to_radix_digits_tb.sv
// Self-checking testbench for signed_integer_to_radix_digits_top.
// Predicts the character stream of every accepted value and checks it word by word.
// Depends on sitrd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
   import sitrd_pkg::*;

   localparam int VALUE_W = DEFAULT_VALUE_BITS;
   // The spare register index decodes to nothing and must leave the settings alone.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 1_000_000;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              empty_res;
      logic              last;
   } text_char_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {BAD_PLUS, BAD_MINUS, BAD_LOW, BAD_HIGH, BAD_REPEAT, BAD_RADIX}
      bad_kind_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [VALUE_W-1:0]     req_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [CHAR_W-1:0]      rsp_char_code;
   logic                   rsp_empty_res;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ALPHA_W-1:0]     csr_data;

   // Shadow copy of the settings; the alphabet is kept as one 16-character vector.
   logic [RADIX_W-1:0]     cfg_radix;
   logic [2*ALPHA_W-1:0]   cfg_alpha;

   text_char_type expected_text[$];
   int         mismatch_count;
   int         values_sent;
   int         chars_checked;
   int         cycle_count;
   int         sender_idle_pct;
   int         stall_pct;
   bit         hold_pending;
   int         hold_left;

   signed_integer_to_radix_digits_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_empty_res (rsp_empty_res),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   function automatic logic [CHAR_W-1:0] alpha_at(input int idx);
      return cfg_alpha[8*idx +: 8];
   endfunction

   // The alphabet is checked on every conversion: radix in range, every character in
   // use printable, neither sign character, and no character used twice.
   function automatic bit alphabet_valid();
      logic [CHAR_W-1:0] c;
      if (cfg_radix < 2 || cfg_radix > MAX_RADIX) return 1'b0;
      for (int i = 0; i < cfg_radix; i++) begin
         c = alpha_at(i);
         if (c == CHAR_PLUS || c == CHAR_MINUS || c < CHAR_LOW || c > CHAR_HIGH)
            return 1'b0;
         for (int j = 0; j < i; j++)
            if (alpha_at(j) == c) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Queues the characters that one accepted value must produce.
   function automatic void predict_text(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] base;
      logic [DIGIT_W-1:0] digits [VALUE_W];
      int                 n;
      bit                 neg;
      if (!alphabet_valid()) begin
         expected_text.push_back('{char_code: CHAR_NONE, empty_res: 1'b1, last: 1'b1});
         return;
      end
      neg  = value[VALUE_W-1];
      // Unsigned negation gives 2^31 for the most negative value, as required.
      mag  = neg ? -value : value;
      base = VALUE_W'(cfg_radix);
      n    = 0;
      do begin
         digits[n] = DIGIT_W'(mag % base);
         mag = mag / base;
         n++;
      end while (mag != 0);
      if (neg)
         expected_text.push_back('{char_code: CHAR_MINUS, empty_res: 1'b0, last: 1'b0});
      for (int k = n - 1; k >= 0; k--)
         expected_text.push_back('{char_code: alpha_at(digits[k]), empty_res: 1'b0,
                                   last: (k == 0)});
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(3))
         0: v = $urandom;
         1: v = $urandom_range(200) - 100;
         2: begin
            v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            // Flipping the magnitude bits turns the two extremes into -1 and 0.
            if ($urandom_range(2) == 0) v = v ^ 32'h7FFF_FFFF;
         end
         default: begin
            v = $urandom >> $urandom_range(31);
            if ($urandom_range(1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // Distinct printable characters for the digits in use, random bytes above them.
   function automatic logic [2*ALPHA_W-1:0] make_alphabet(input int r);
      logic [2*ALPHA_W-1:0] alpha;
      logic [CHAR_W-1:0]    c;
      bit                   fresh;
      for (int i = 0; i < ALPHA_CHARS; i++) begin
         if (i < r) begin
            do begin
               c = CHAR_W'($urandom_range(CHAR_LOW, CHAR_HIGH));
               fresh = (c != CHAR_PLUS && c != CHAR_MINUS);
               for (int j = 0; j < i; j++)
                  if (alpha[8*j +: 8] == c) fresh = 1'b0;
            end while (!fresh);
         end else begin
            c = CHAR_W'($urandom);
         end
         alpha[8*i +: 8] = c;
      end
      return alpha;
   endfunction

   // Breaks an otherwise good setting in one random way.
   function automatic void spoil_alphabet(input int r, inout logic [2*ALPHA_W-1:0] alpha,
                                          inout logic [ALPHA_W-1:0] radix_data);
      bad_kind_type kind;
      int           pos;
      int           other;
      kind = bad_kind_type'($urandom_range(5));
      pos  = $urandom_range(r - 1);
      case (kind)
         BAD_PLUS:  alpha[8*pos +: 8] = CHAR_PLUS;
         BAD_MINUS: alpha[8*pos +: 8] = CHAR_MINUS;
         BAD_LOW:   alpha[8*pos +: 8] = CHAR_W'($urandom_range(CHAR_LOW - 1));
         BAD_HIGH:  alpha[8*pos +: 8] = CHAR_W'($urandom_range(CHAR_HIGH + 1, 255));
         BAD_REPEAT: begin
            other = (pos + 1 + $urandom_range(r - 2)) % r;
            alpha[8*pos +: 8] = alpha[8*other +: 8];
         end
         default: radix_data[RADIX_W-1:0] = RADIX_W'(
            $urandom_range(1) ? $urandom_range(1) : $urandom_range(MAX_RADIX + 1, 31));
      endcase
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin sender_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 77; stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 77; end
         default:       begin sender_idle_pct = 31; stall_pct = 31; end
      endcase
   endtask

   // Offers one value and returns at the edge where the word is taken. Valid is left
   // high so that a following value can go out at once without a gap.
   task automatic send_value(input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_text(value);
      values_sent++;
   endtask

   // Stops offering values and waits until every expected character has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_RADIX:      cfg_radix = data[RADIX_W-1:0];
         CSR_ALPHA_LOW:  cfg_alpha[ALPHA_W-1:0] = data;
         CSR_ALPHA_HIGH: cfg_alpha[2*ALPHA_W-1:ALPHA_W] = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Settings change only while the block is idle.
   task automatic set_config(input logic [ALPHA_W-1:0] radix_data,
                             input logic [2*ALPHA_W-1:0] alpha);
      wait_drained();
      write_csr(CSR_RADIX, radix_data);
      write_csr(CSR_ALPHA_LOW, alpha[ALPHA_W-1:0]);
      write_csr(CSR_ALPHA_HIGH, alpha[2*ALPHA_W-1:ALPHA_W]);
   endtask

   // The radix word carries random upper bits, which the block must ignore.
   function automatic logic [ALPHA_W-1:0] radix_word(input int r);
      logic [ALPHA_W-1:0] w;
      w = {$urandom, $urandom};
      w[RADIX_W-1:0] = RADIX_W'(r);
      return w;
   endfunction

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Decimal digits straight out of reset, with zero, one, minus one and both extremes.
   task automatic test_reset_decimal();
      set_idling(IDLE_NONE);
      send_value(32'h0000_0000);
      send_value(32'h0000_0001);
      send_value(32'hFFFF_FFFF);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
   endtask

   // Binary gives the longest text; the alphabet uses the lowest and highest
   // printable characters. Then hexadecimal with capital letters.
   task automatic test_radix_extremes();
      logic [2*ALPHA_W-1:0] alpha;
      alpha = make_alphabet(0);
      alpha[7:0]  = CHAR_LOW;
      alpha[15:8] = CHAR_HIGH;
      set_config(radix_word(2), alpha);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'h0000_0000);
      set_config(radix_word(MAX_RADIX), {64'h4645_4443_4241_3938, 64'h3736_3534_3332_3130});
      send_value(32'h8000_0000);
      send_value(32'hFFFF_FFFF);
   endtask

   task automatic test_spare_register();
      wait_drained();
      write_csr(CSR_SPARE, {$urandom, $urandom});
      send_value(32'h1234_5678);
   endtask

   // Each way an alphabet can be bad, starting from the decimal reset alphabet.
   task automatic test_invalid_alphabets();
      logic [2*ALPHA_W-1:0] base;
      logic [2*ALPHA_W-1:0] alpha;
      base = {ALPHA_HIGH_RESET, ALPHA_LOW_RESET};
      set_config(radix_word(0), base);
      send_value($urandom);
      set_config(radix_word(1), base);
      send_value($urandom);
      set_config(radix_word(MAX_RADIX + 1), base);
      send_value($urandom);
      set_config({ALPHA_W{1'b1}}, base);
      send_value($urandom);
      alpha = base; alpha[8*3 +: 8] = CHAR_PLUS;
      set_config(radix_word(10), alpha);
      send_value($urandom);
      alpha = base; alpha[8*0 +: 8] = CHAR_MINUS;
      set_config(radix_word(10), alpha);
      send_value($urandom);
      alpha = base; alpha[8*9 +: 8] = CHAR_W'(CHAR_LOW - 1);
      set_config(radix_word(10), alpha);
      send_value($urandom);
      alpha = base; alpha[8*5 +: 8] = CHAR_W'(CHAR_HIGH + 1);
      set_config(radix_word(10), alpha);
      send_value($urandom);
      alpha = base; alpha[8*7 +: 8] = alpha[8*2 +: 8];
      set_config(radix_word(10), alpha);
      send_value($urandom);
      // A bad character above the digits in use does not matter.
      alpha = base; alpha[8*12 +: 8] = CHAR_PLUS;
      set_config(radix_word(10), alpha);
      send_value(-32'sd42);
   endtask

   // The output is held off for a long stretch while values keep coming, so the block
   // fills up and stalls its input. Afterwards the sender waits for a full drain.
   task automatic test_backpressure();
      set_idling(IDLE_NONE);
      set_config(radix_word(8), make_alphabet(8));
      hold_pending = 1'b1;
      for (int i = 0; i < 8; i++) send_value(random_value());
      wait_drained();
      for (int i = 0; i < 4; i++) send_value(random_value());
   endtask

   // Mostly good random alphabets with random values, some broken settings as noise;
   // each phase runs under its own idle pattern.
   task automatic test_random_phases();
      logic [2*ALPHA_W-1:0] alpha;
      logic [ALPHA_W-1:0]   radix_data;
      int                   r;
      for (int phase = 0; phase < 8; phase++) begin
         set_idling(idle_mode_type'(phase % 4));
         r = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : $urandom_range(2, MAX_RADIX);
         alpha = make_alphabet(r);
         radix_data = radix_word(r);
         if ($urandom_range(4) == 0) spoil_alphabet(r, alpha, radix_data);
         // Now and then the whole alphabet is random, reaching the top bit of every byte.
         if ($urandom_range(7) == 0) alpha = {$urandom, $urandom, $urandom, $urandom};
         set_config(radix_data, alpha);
         for (int i = 0; i < 12; i++) send_value(random_value());
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Result checking and output-side readiness
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected word char_code %h empty_res %b last %b",
                     $time, rsp_char_code, rsp_empty_res, rsp_last);
            mismatch_count++;
         end else begin
            want = expected_text.pop_front();
            chars_checked++;
            if (rsp_char_code !== want.char_code) begin
               $display("%0t: char_code expected %h got %h", $time, want.char_code,
                        rsp_char_code);
               mismatch_count++;
            end
            if (rsp_empty_res !== want.empty_res) begin
               $display("%0t: empty_res expected %b got %b", $time, want.empty_res,
                        rsp_empty_res);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %b got %b", $time, want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
      if (hold_pending) begin
         hold_left = HOLD_CYCLES;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d words outstanding", $time, expected_text.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_value      <= '0;
      rsp_ready      <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_RADIX;
      csr_data       <= '0;
      cfg_radix       = RADIX_RESET;
      cfg_alpha       = {ALPHA_HIGH_RESET, ALPHA_LOW_RESET};
      mismatch_count  = 0;
      values_sent     = 0;
      chars_checked   = 0;
      cycle_count     = 0;
      hold_pending    = 1'b0;
      hold_left       = 0;
      set_idling(IDLE_NONE);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_decimal();
      test_radix_extremes();
      test_spare_register();
      test_invalid_alphabets();
      test_backpressure();
      test_random_phases();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Converted %0d values into %0d checked words in radixes 2 to 16,",
               values_sent, chars_checked);
      $display("with bad alphabets, four idle patterns and a long output hold-off.");
      if (mismatch_count == 0 && expected_text.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
